/* src/mbps_pkg.sv */
// Shared types and constants of the masked byte pattern search core.
`timescale 1ns / 1ps

package mbps_pkg;

  localparam int MAX_PATTERN = 16;
  localparam int HIST_DEPTH  = MAX_PATTERN - 1;
  localparam int LEN_W       = $clog2(MAX_PATTERN) + 1;
  localparam int OFFSET_W    = 32;
  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 64;

  typedef enum logic [1:0] {
    REG_PATTERN_LOW    = 2'd0,
    REG_PATTERN_HIGH   = 2'd1,
    REG_WILDCARD_MASK  = 2'd2,
    REG_PATTERN_LENGTH = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [MAX_PATTERN*8-1:0] pattern;
    logic [MAX_PATTERN-1:0]   wild;
    logic [LEN_W-1:0]         length;
  } cfg_t;

  typedef struct packed {
    logic                produce;
    logic                found;
    logic [OFFSET_W-1:0] offset;
  } result_t;

endpackage

/* src/masked_byte_pattern_search_core.sv */
// Top level of the masked byte pattern search core.
//
//   Channel  Signals                          Direction
//   input    in_valid/in_ready, data_byte,    into the core
//            last_byte
//   output   out_valid/out_ready, found,      out of the core
//            match_offset
//   config   psel/penable/pwrite/paddr/       APB-style, 64-bit registers
//            pwdata/prdata/pready             at byte addresses 0, 8, 16, 24
//
// A byte is taken into the input register and compared against the pattern from
// there; its result, if any, is loaded into the output register once that register
// is free, so a result passes the input and then the output register, and one byte
// can be accepted in every cycle while no result is stalled in the output register.
// The window compare between the input and output registers sets this rate.
// Reset is synchronous and clears the valid flags, configuration and match state.
// A stalled result holds the input register, which then backs up the input.
`timescale 1ns / 1ps

module masked_byte_pattern_search_core import mbps_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                found,
  output logic [OFFSET_W-1:0] match_offset,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready
);

  cfg_t       cfg;
  result_t    res;
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic       out_free;
  logic       step;

  mbps_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mbps_window u_window (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .data_byte (s1_byte),
    .last_byte (s1_last),
    .cfg       (cfg),
    .res       (res)
  );

  assign out_free = !out_valid || out_ready;
  assign step     = s1_valid && out_free;
  assign in_ready = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= data_byte;
      s1_last <= last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && res.produce) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res.produce) begin
      found        <= res.found;
      match_offset <= res.offset;
    end
  end

`ifndef SYNTHESIS
  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> match_offset == '0)
    else $error("Not-found result carries a nonzero offset.");

  a_stage_held: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_free |=> s1_valid && $stable(s1_byte) && $stable(s1_last))
    else $error("Input register lost its byte while the output was stalled.");
`endif

endmodule

/* src/mbps_cfg_regs.sv */
// Configuration register file with an APB-style access port.
`timescale 1ns / 1ps

module mbps_cfg_regs import mbps_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [63:0] pattern_low;
  logic [63:0] pattern_high;
  logic [15:0] wildcard_mask;
  logic [4:0]  pattern_length;
  logic        wr_en;
  reg_index_t  reg_index;

  assign pready    = 1'b1;
  assign wr_en     = psel && penable && pwrite;
  assign reg_index = reg_index_t'(paddr[4:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      wildcard_mask  <= '0;
      pattern_length <= 5'd1;
    end else if (wr_en) begin
      unique case (reg_index)
        REG_PATTERN_LOW:    pattern_low    <= pwdata;
        REG_PATTERN_HIGH:   pattern_high   <= pwdata;
        REG_WILDCARD_MASK:  wildcard_mask  <= pwdata[15:0];
        REG_PATTERN_LENGTH: pattern_length <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_PATTERN_LOW:    prdata = pattern_low;
      REG_PATTERN_HIGH:   prdata = pattern_high;
      REG_WILDCARD_MASK:  prdata = {48'd0, wildcard_mask};
      REG_PATTERN_LENGTH: prdata = {59'd0, pattern_length};
      default:            prdata = '0;
    endcase
  end

  always_comb begin
    cfg.pattern = {pattern_high, pattern_low};
    cfg.wild    = {wildcard_mask[15:1], 1'b0};
    if (pattern_length == '0) begin
      cfg.length = LEN_W'(1);
    end else if (pattern_length > LEN_W'(MAX_PATTERN)) begin
      cfg.length = LEN_W'(MAX_PATTERN);
    end else begin
      cfg.length = pattern_length;
    end
  end

endmodule

/* src/mbps_window.sv */
// Byte history, offset counter and window compare of the pattern search.
`timescale 1ns / 1ps

module mbps_window import mbps_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  input  cfg_t       cfg,
  output result_t    res
);

  logic [HIST_DEPTH*8-1:0]  hist;
  logic [OFFSET_W-1:0]      bytes_seen;
  logic                     match_reported;
  logic [MAX_PATTERN*8-1:0] window;
  logic [MAX_PATTERN*8-1:0] reversed;
  logic [MAX_PATTERN*8-1:0] aligned;
  logic [LEN_W-1:0]         shift;
  logic [OFFSET_W-1:0]      len_m1;
  logic                     pos_ok;
  logic                     enough;
  logic                     match;

  assign window = {hist, data_byte};
  assign shift  = LEN_W'(MAX_PATTERN) - cfg.length;
  assign len_m1 = OFFSET_W'(cfg.length) - OFFSET_W'(1);

  always_comb begin
    for (int j = 0; j < MAX_PATTERN; j++) begin
      reversed[j*8 +: 8] = window[(MAX_PATTERN-1-j)*8 +: 8];
    end
    aligned = reversed >> {shift, 3'b000};
    pos_ok  = 1'b1;
    for (int p = 0; p < MAX_PATTERN; p++) begin
      if ((LEN_W'(p) < cfg.length) && !cfg.wild[p] &&
          (aligned[p*8 +: 8] != cfg.pattern[p*8 +: 8])) begin
        pos_ok = 1'b0;
      end
    end
  end

  assign enough = bytes_seen >= len_m1;
  assign match  = !match_reported && enough && pos_ok;

  always_comb begin
    res.produce = match || (last_byte && !match_reported);
    res.found   = match;
    res.offset  = match ? (bytes_seen - len_m1) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen     <= '0;
      match_reported <= 1'b0;
    end else if (step) begin
      if (last_byte) begin
        bytes_seen     <= '0;
        match_reported <= 1'b0;
      end else begin
        if (bytes_seen != '1) begin
          bytes_seen <= bytes_seen + OFFSET_W'(1);
        end
        if (match) begin
          match_reported <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && !last_byte) begin
      hist <= {hist[(HIST_DEPTH-1)*8-1:0], data_byte};
    end
  end

`ifndef SYNTHESIS
  a_clear_on_last: assert property (@(posedge clk) disable iff (rst)
    step && last_byte |=> (bytes_seen == '0) && !match_reported)
    else $error("Search state not cleared after the last byte.");

  a_mark_on_found: assert property (@(posedge clk) disable iff (rst)
    step && res.found && !last_byte |=> match_reported)
    else $error("Match not recorded after a found result.");

  a_single_found: assert property (@(posedge clk) disable iff (rst)
    match_reported |-> !res.found)
    else $error("Second match reported within one buffer.");
`endif

endmodule

/* bench/tb_masked_byte_pattern_search_core.sv */
// Self-checking testbench of the masked byte pattern search core.
`timescale 1ns / 1ps

module tb_masked_byte_pattern_search_core;
  import mbps_pkg::*;

  typedef struct packed {
    logic                found;
    logic [OFFSET_W-1:0] offset;
  } search_result_t;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic [7:0]          data_byte;
  logic                last_byte;
  logic                out_valid;
  logic                out_ready;
  logic                found;
  logic [OFFSET_W-1:0] match_offset;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  // Register shadows.
  logic [63:0]             pattern_lo_q = '0;
  logic [63:0]             pattern_hi_q = '0;
  logic [15:0]             wildcard_q   = '0;
  logic [4:0]              length_q     = 5'd1;

  // Search state of the predictor.
  logic [7:0]              history [0:HIST_DEPTH-1] = '{default: 8'h00};
  logic [OFFSET_W-1:0]     offset_count = '0;
  logic                    match_done   = 1'b0;

  search_result_t          expected_results [$];
  search_result_t          oldest_result;
  logic [7:0]              buffer_bytes [$];

  int unsigned             error_count = 0;
  int                      hold_cycles = 0;
  bit                      no_idle     = 1'b0;

  masked_byte_pattern_search_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .found        (found),
    .match_offset (match_offset),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("MISMATCH at %0t: %s, expected %0d, got %0d", $realtime, what, want, got);
    error_count++;
  endtask

  function automatic int unsigned effective_length();
    if (length_q == 5'd0) return 1;
    if (length_q > MAX_PATTERN) return MAX_PATTERN;
    return length_q;
  endfunction

  function automatic logic [7:0] pattern_byte(input int unsigned pos);
    logic [127:0] bytes;
    bytes = {pattern_hi_q, pattern_lo_q};
    return bytes[8*pos +: 8];
  endfunction

  function automatic bit is_wildcard(input int unsigned pos);
    return pos != 0 && wildcard_q[pos];
  endfunction

  task automatic predict_search(input logic [7:0] b, input logic last);
    int unsigned    span;
    int unsigned    pos;
    int             k;
    bit             hit;
    logic [7:0]     seen_byte;
    search_result_t res;
    span = effective_length();
    hit = 1'b0;
    if (!match_done && offset_count >= span - 1) begin
      hit = 1'b1;
      for (pos = 0; pos < span; pos++) begin
        seen_byte = (pos == span - 1) ? b : history[span - 2 - pos];
        if (!is_wildcard(pos) && seen_byte != pattern_byte(pos)) hit = 1'b0;
      end
      if (hit) begin
        res.found = 1'b1;
        res.offset = offset_count - OFFSET_W'(span - 1);
        expected_results.push_back(res);
        match_done = 1'b1;
      end
    end
    if (last) begin
      if (!match_done) begin
        res.found = 1'b0;
        res.offset = '0;
        expected_results.push_back(res);
      end
      for (k = 0; k < HIST_DEPTH; k++) history[k] = 8'h00;
      offset_count = '0;
      match_done = 1'b0;
    end else begin
      for (k = HIST_DEPTH - 1; k > 0; k--) history[k] = history[k-1];
      history[0] = b;
      if (offset_count != '1) offset_count = offset_count + 1'b1;
    end
  endtask

  // Entered and left at a falling edge; valid stays high into the next call.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while (!no_idle && $urandom_range(0, 99) < 29) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    last_byte <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_search(b, last);
    @(negedge clk);
  endtask

  task automatic send_buffer();
    int unsigned idx;
    for (idx = 0; idx < buffer_bytes.size(); idx++)
      send_byte(buffer_bytes[idx], idx == buffer_bytes.size() - 1);
  endtask

  task automatic settle();
    int unsigned waited;
    waited = 0;
    in_valid <= 1'b0;
    while (expected_results.size() != 0 && waited < 2000) begin
      @(negedge clk);
      waited++;
    end
    if (expected_results.size() != 0) begin
      report_mismatch("results never delivered", 0, expected_results.size());
      expected_results.delete();
    end
    repeat (8) @(negedge clk);
  endtask

  task automatic write_register(input reg_index_t idx, input logic [63:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_PATTERN_LOW:    pattern_lo_q = value;
      REG_PATTERN_HIGH:   pattern_hi_q = value;
      REG_WILDCARD_MASK:  wildcard_q = value[15:0];
      REG_PATTERN_LENGTH: length_q = value[4:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic configure(input logic [63:0] lo, input logic [63:0] hi,
                           input logic [15:0] wild, input logic [4:0] len);
    settle();
    write_register(REG_PATTERN_LOW, lo);
    write_register(REG_PATTERN_HIGH, hi);
    write_register(REG_WILDCARD_MASK, {48'h0, wild});
    write_register(REG_PATTERN_LENGTH, {59'h0, len});
  endtask

  task automatic configure_random();
    logic [15:0] wild;
    logic [4:0]  len;
    case ($urandom_range(0, 3))
      0: wild = '0;
      1: wild = 16'($urandom & $urandom & $urandom);
      2: wild = 16'($urandom);
      default: wild = 16'($urandom & $urandom);
    endcase
    case ($urandom_range(0, 9))
      0: len = 5'd1;
      1: len = 5'd2;
      2: len = 5'd16;
      3: len = 5'($urandom_range(17, 31));
      default: len = 5'($urandom_range(1, 16));
    endcase
    configure({$urandom, $urandom}, {$urandom, $urandom}, wild, len);
  endtask

  function automatic logic [7:0] near_byte();
    if ($urandom_range(0, 1) == 0) return pattern_byte($urandom_range(0, effective_length() - 1));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic build_random_buffer();
    int unsigned span;
    int unsigned kind;
    int unsigned cut;
    int unsigned pos;
    span = effective_length();
    kind = $urandom_range(0, 9);
    buffer_bytes.delete();
    if (kind <= 6) begin
      // A planted occurrence, or a truncated one for the broken case.
      repeat ($urandom_range(0, 12)) buffer_bytes.push_back(near_byte());
      cut = (kind == 6) ? $urandom_range(0, span - 1) : span;
      for (pos = 0; pos < cut; pos++)
        buffer_bytes.push_back(is_wildcard(pos) ? 8'($urandom_range(0, 255))
                                                : pattern_byte(pos));
      if (kind != 6) repeat ($urandom_range(0, 8)) buffer_bytes.push_back(near_byte());
      if (buffer_bytes.size() == 0) buffer_bytes.push_back(near_byte());
    end else if (kind == 7) begin
      repeat ($urandom_range(1, 30)) buffer_bytes.push_back(8'($urandom_range(0, 255)));
    end else if (kind == 8) begin
      repeat ($urandom_range(1, 30))
        buffer_bytes.push_back(pattern_byte($urandom_range(0, span - 1)));
    end else begin
      repeat ($urandom_range(1, 3)) buffer_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_random_bytes(input int unsigned count);
    int unsigned sent;
    sent = 0;
    while (sent < count) begin
      build_random_buffer();
      send_buffer();
      sent += buffer_bytes.size();
    end
  endtask

  task automatic test_reset_defaults();
    buffer_bytes = '{8'h11, 8'h00, 8'h22};
    send_buffer();
    buffer_bytes = '{8'hFF};
    send_buffer();
    buffer_bytes = '{8'h00};
    send_buffer();
  endtask

  task automatic test_oversized_length();
    configure('1, '1, 16'h0000, 5'd31);
    buffer_bytes.delete();
    repeat (16) buffer_bytes.push_back(8'hFF);
    send_buffer();
  endtask

  task automatic test_zero_length();
    configure('0, '0, 16'hFFFF, 5'd0);
    buffer_bytes = '{8'hFF, 8'h00};
    send_buffer();
  endtask

  task automatic test_random_buffers();
    int unsigned phase;
    for (phase = 0; phase < 7; phase++) begin
      configure_random();
      no_idle = (phase == 3);
      run_random_bytes(100);
    end
    no_idle = 1'b0;
  endtask

  task automatic test_output_backpressure();
    configure_random();
    hold_cycles = 300;
    run_random_bytes(120);
  endtask

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles = hold_cycles - 1;
      end else begin
        out_ready <= no_idle || ($urandom_range(0, 99) >= 29);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result transfer with nothing expected", 0, match_offset);
      end else begin
        oldest_result = expected_results.pop_front();
        if (found !== oldest_result.found)
          report_mismatch("found", 32'(oldest_result.found), 32'(found));
        if (match_offset !== oldest_result.offset)
          report_mismatch("match_offset", oldest_result.offset, match_offset);
      end
    end
  end

  initial begin
    #400000;
    $display("masked_byte_pattern_search_core test failed");
    $finish;
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    data_byte = 8'h00;
    last_byte = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_reset_defaults();
    test_oversized_length();
    test_zero_length();
    test_random_buffers();
    test_output_backpressure();
    settle();
    if (error_count == 0) begin
      $display("masked_byte_pattern_search_core test passed");
    end else begin
      $display("masked_byte_pattern_search_core test failed");
    end
    $finish;
  end

endmodule
